// ===== rtl/sbbs_pkg.sv =====
// Shared types and operation codes for the sliding base bitmap set unit.
`default_nettype none

package sbbs_pkg;

   localparam logic [2:0] FUNC_ADD      = 3'd0;
   localparam logic [2:0] FUNC_REMOVE   = 3'd1;
   localparam logic [2:0] FUNC_CONTAINS = 3'd2;
   localparam logic [2:0] FUNC_CLEAR    = 3'd3;
   localparam logic [2:0] FUNC_NEXT     = 3'd4;

   localparam int unsigned COUNT_BITS = 11;

   typedef struct packed {
      logic [2:0]         func;
      logic signed [31:0] item_value;
   } req_type;

   typedef struct packed {
      logic                  status;
      logic                  is_member;
      logic signed [31:0]    found_value;
      logic [COUNT_BITS-1:0] member_count;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/sliding_base_bitmap_set_unit.sv =====
// Top level of the sliding base bitmap set unit: sequencer, bitmap memory and scan.
// Add, remove and contains read and may update a memory word only when the item lies
// in the window; clear sweeps all DEPTH words only when the set holds members.
// Next scans the memory one word per cycle until it finds a member or the scan ends.
// One item is in work at a time; a new item is taken while a result waits.
// After reset a clearing pass writes all DEPTH words before the first item.
`default_nettype none

module sliding_base_bitmap_set_unit #(
   parameter int unsigned WINDOW = 1024
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sbbs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sbbs_pkg::rsp_type     rsp_data
);

   import sbbs_pkg::*;

   localparam int unsigned WB    = (WINDOW >= 64) ? 32 : 4;
   localparam int unsigned WBL   = $clog2(WB);
   localparam int unsigned DEPTH = (WINDOW + WB - 1) / WB;
   localparam int unsigned PW    = $clog2(WINDOW);
   localparam int unsigned AW    = PW - WBL;
   localparam int unsigned SW    = $clog2(WINDOW + 1);
   localparam int unsigned LW    = $clog2(DEPTH + 2);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_PREP, S_DECIDE, S_ADDR, S_READ, S_MOD,
      S_SCAN, S_CHECK, S_FOUND, S_SWEEP, S_DONE
   } state_type;

   state_type          state_ff;
   logic [2:0]         op_ff;
   logic [31:0]        val_ff;
   logic [31:0]        base_ff;
   logic [SW-1:0]      span_ff;
   logic [SW-1:0]      cnt_ff;
   logic [PW-1:0]      pbase_ff;
   logic signed [33:0] diff_ff;
   logic [PW-1:0]      off_ff;
   logic [PW-1:0]      paddr_ff;
   logic [PW-1:0]      fpos_ff;
   logic [PW-1:0]      lpos_ff;
   logic [AW-1:0]      swp_ff;
   logic [AW-1:0]      scan_addr_ff;
   logic [AW-1:0]      ex_addr_ff;
   logic [LW-1:0]      scan_left_ff;
   logic               inflight_ff;
   logic               first_ff;
   logic               status_ff;
   logic               memb_ff;
   logic [31:0]        found_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [WB-1:0]      mem [DEPTH];
   logic [WB-1:0]      rd_ff;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic [WB-1:0]      mem_wd;
   logic [AW-1:0]      mem_ra;

   logic [33:0]        low_gap;
   logic               lo_fits;
   logic [PW:0]        lo_pb;
   logic [PW:0]        lo_pb_wrap;
   logic               below_span;
   logic               hi_fits;
   logic [PW:0]        psum;
   logic [PW:0]        psum_wrap;
   logic [PW:0]        ldiff;
   logic [PW:0]        ldiff_wrap;
   logic [WB-1:0]      bit_mask;
   logic               cur_bit;
   logic [WB-1:0]      first_mask;
   logic [WB-1:0]      scan_word;
   logic               fhit;
   logic [WBL-1:0]     fidx;
   logic               rsp_free;

   always_comb begin
      low_gap    = 34'd0 - 34'(diff_ff);
      lo_fits    = (low_gap + 34'(span_ff)) <= 34'(WINDOW);
      lo_pb      = (PW+1)'(pbase_ff) - (PW+1)'(low_gap[PW-1:0]);
      lo_pb_wrap = lo_pb[PW] ? lo_pb + (PW+1)'(WINDOW) : lo_pb;
      below_span = diff_ff < $signed(34'(span_ff));
      hi_fits    = diff_ff < $signed(34'(WINDOW));
      psum       = (PW+1)'(pbase_ff) + (PW+1)'(off_ff);
      psum_wrap  = (psum >= (PW+1)'(WINDOW)) ? psum - (PW+1)'(WINDOW) : psum;
      ldiff      = (PW+1)'(fpos_ff) - (PW+1)'(pbase_ff);
      ldiff_wrap = ldiff[PW] ? ldiff + (PW+1)'(WINDOW) : ldiff;
      bit_mask   = WB'(1) << paddr_ff[WBL-1:0];
      cur_bit    = |(rd_ff & bit_mask);
      first_mask = {WB{1'b1}} << paddr_ff[WBL-1:0];
      scan_word  = rd_ff & (first_ff ? first_mask : {WB{1'b1}});
      rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   sbbs_word_find #(
      .WB (WB)
   ) u_find (
      .word (scan_word),
      .hit  (fhit),
      .idx  (fidx)
   );

   always_comb begin
      mem_we = 1'b0;
      mem_wa = paddr_ff[PW-1:WBL];
      mem_wd = rd_ff;
      mem_ra = (state_ff == S_SCAN) ? scan_addr_ff : paddr_ff[PW-1:WBL];
      unique case (state_ff)
         S_INIT, S_SWEEP: begin
            mem_we = 1'b1;
            mem_wa = swp_ff;
            mem_wd = '0;
         end
         S_MOD: begin
            if (op_ff == FUNC_ADD && !cur_bit) begin
               mem_we = 1'b1;
               mem_wd = rd_ff | bit_mask;
            end else if (op_ff == FUNC_REMOVE && cur_bit) begin
               mem_we = 1'b1;
               mem_wd = rd_ff & ~bit_mask;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         base_ff      <= 32'd1;
         span_ff      <= '0;
         cnt_ff       <= '0;
         pbase_ff     <= '0;
         swp_ff       <= '0;
         inflight_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_INIT, S_SWEEP: begin
               swp_ff <= (swp_ff == AW'(DEPTH - 1)) ? '0 : swp_ff + AW'(1);
               if (swp_ff == AW'(DEPTH - 1)) begin
                  state_ff <= (state_ff == S_INIT) ? S_IDLE : S_DONE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  op_ff     <= req_data.func;
                  val_ff    <= req_data.item_value;
                  status_ff <= 1'b0;
                  memb_ff   <= 1'b0;
                  found_ff  <= '0;
                  state_ff  <= S_PREP;
               end
            end
            S_PREP: begin
               diff_ff  <= $signed({{2{val_ff[31]}}, val_ff} - {{2{base_ff[31]}}, base_ff});
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               unique case (op_ff)
                  FUNC_ADD: begin
                     if (cnt_ff == '0) begin
                        base_ff  <= val_ff;
                        span_ff  <= SW'(1);
                        pbase_ff <= '0;
                        off_ff   <= '0;
                        state_ff <= S_ADDR;
                     end else if (diff_ff < 0) begin
                        if (lo_fits) begin
                           base_ff  <= val_ff;
                           span_ff  <= span_ff + SW'(low_gap[PW-1:0]);
                           pbase_ff <= lo_pb_wrap[PW-1:0];
                           off_ff   <= '0;
                           state_ff <= S_ADDR;
                        end else begin
                           status_ff <= 1'b1;
                           state_ff  <= S_DONE;
                        end
                     end else if (!below_span) begin
                        if (hi_fits) begin
                           span_ff  <= SW'(diff_ff[PW-1:0]) + SW'(1);
                           off_ff   <= diff_ff[PW-1:0];
                           state_ff <= S_ADDR;
                        end else begin
                           status_ff <= 1'b1;
                           state_ff  <= S_DONE;
                        end
                     end else begin
                        off_ff   <= diff_ff[PW-1:0];
                        state_ff <= S_ADDR;
                     end
                  end
                  FUNC_REMOVE, FUNC_CONTAINS: begin
                     if (diff_ff >= 0 && below_span) begin
                        off_ff   <= diff_ff[PW-1:0];
                        state_ff <= S_ADDR;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
                  FUNC_CLEAR: begin
                     base_ff  <= 32'd1;
                     span_ff  <= '0;
                     cnt_ff   <= '0;
                     pbase_ff <= '0;
                     if (cnt_ff != '0) begin
                        state_ff <= S_SWEEP;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
                  FUNC_NEXT: begin
                     if (span_ff != '0 && below_span) begin
                        off_ff   <= (diff_ff < 0) ? '0 : diff_ff[PW-1:0];
                        state_ff <= S_ADDR;
                     end else begin
                        state_ff <= S_DONE;
                     end
                  end
                  default: begin
                     state_ff <= S_DONE;
                  end
               endcase
            end
            S_ADDR: begin
               paddr_ff <= psum_wrap[PW-1:0];
               if (op_ff == FUNC_NEXT) begin
                  scan_addr_ff <= psum_wrap[PW-1:WBL];
                  scan_left_ff <= LW'(DEPTH + 1);
                  inflight_ff  <= 1'b0;
                  first_ff     <= 1'b1;
                  state_ff     <= S_SCAN;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_READ: begin
               state_ff <= S_MOD;
            end
            S_MOD: begin
               if (op_ff == FUNC_ADD && !cur_bit) begin
                  cnt_ff <= cnt_ff + SW'(1);
               end else if (op_ff == FUNC_REMOVE && cur_bit) begin
                  cnt_ff <= cnt_ff - SW'(1);
               end
               memb_ff  <= (op_ff == FUNC_CONTAINS) && cur_bit;
               state_ff <= S_DONE;
            end
            S_SCAN: begin
               if (inflight_ff && fhit) begin
                  fpos_ff     <= {ex_addr_ff, fidx};
                  inflight_ff <= 1'b0;
                  state_ff    <= S_CHECK;
               end else if (!inflight_ff && scan_left_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  if (scan_left_ff != '0) begin
                     ex_addr_ff   <= scan_addr_ff;
                     scan_addr_ff <= (scan_addr_ff == AW'(DEPTH - 1)) ? '0
                                                                      : scan_addr_ff + AW'(1);
                     scan_left_ff <= scan_left_ff - LW'(1);
                     inflight_ff  <= 1'b1;
                  end else begin
                     inflight_ff <= 1'b0;
                  end
                  if (inflight_ff) begin
                     first_ff <= 1'b0;
                  end
               end
            end
            S_CHECK: begin
               lpos_ff  <= ldiff_wrap[PW-1:0];
               state_ff <= S_FOUND;
            end
            S_FOUND: begin
               if (lpos_ff >= off_ff) begin
                  memb_ff  <= 1'b1;
                  found_ff <= base_ff + 32'(lpos_ff);
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_ff.status       <= status_ff;
                  rsp_ff.is_member    <= memb_ff;
                  rsp_ff.found_value  <= found_ff;
                  rsp_ff.member_count <= COUNT_BITS'(cnt_ff);
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_in_span: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= span_ff)
      else $error("member count exceeds window span");

   a_pbase_range: assert property (@(posedge clock) disable iff (reset)
      32'(pbase_ff) < WINDOW)
      else $error("physical base out of range");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside completion");

   a_reject_no_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status |-> !rsp_ff.is_member)
      else $error("rejected add reports a member");

endmodule

`default_nettype wire

// ===== rtl/sbbs_word_find.sv =====
// Finds the lowest set bit of one bitmap word.
`default_nettype none

module sbbs_word_find #(
   parameter int unsigned WB = 32
) (
   input  wire logic [WB-1:0]         word,
   output logic                       hit,
   output logic [$clog2(WB)-1:0]      idx
);

   always_comb begin
      hit = 1'b0;
      idx = '0;
      for (int k = WB - 1; k >= 0; k--) begin
         if (word[k]) begin
            hit = 1'b1;
            idx = ($clog2(WB))'(k);
         end
      end
   end

endmodule

`default_nettype wire
